// File: sv/gcam_pkg.sv
// Package for the GNSS configuration acknowledgement matcher.
// Holds opcodes, status codes, register indexes, the result struct and
// the expected-packet byte function. No dependencies.
`default_nettype none

package gcam_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_ACKED   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [1:0] REG_ACK_CLASS     = 2'd0;
    localparam logic [1:0] REG_ACK_ID        = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  RST_ACK_CLASS     = 8'd6;
    localparam logic [7:0]  RST_ACK_ID        = 8'd36;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3000;

    localparam logic [3:0]  PACKET_LEN  = 4'd10;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [7:0] SYNC_1     = 8'hB5;
    localparam logic [7:0] SYNC_2     = 8'h62;
    localparam logic [7:0] ACK_CLASS  = 8'h05;
    localparam logic [7:0] ACK_ID     = 8'h01;
    localparam logic [7:0] LEN_LO     = 8'h02;
    localparam logic [7:0] LEN_HI     = 8'h00;
    // running checksum constants over the fixed header bytes
    localparam logic [7:0] CKA_BASE   = 8'd8;
    localparam logic [7:0] CKB_BASE   = 8'd43;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] match_count;
    } result_t;

    function automatic logic [7:0] expected_byte(input logic [3:0] pos,
                                                 input logic [7:0] cls,
                                                 input logic [7:0] id);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] b;
        ck_a = CKA_BASE + cls + id;
        ck_b = CKB_BASE + {cls[6:0], 1'b0} + id;
        unique case (pos)
            4'd0:    b = SYNC_1;
            4'd1:    b = SYNC_2;
            4'd2:    b = ACK_CLASS;
            4'd3:    b = ACK_ID;
            4'd4:    b = LEN_LO;
            4'd5:    b = LEN_HI;
            4'd6:    b = cls;
            4'd7:    b = id;
            4'd8:    b = ck_a;
            default: b = ck_b;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/gcam_match.sv
// Matcher state: phase, match index and saturating elapsed tick counter.
// Produces the post-update result for each accepted transaction. Uses gcam_pkg.
`default_nettype none

module gcam_match (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [7:0]       ack_class,
    input  wire logic [7:0]       ack_id,
    input  wire logic [15:0]      timeout_ticks,
    output gcam_pkg::result_t     result
);

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  index_reg, index_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic        hit;

    assign hit = (index_reg < gcam_pkg::PACKET_LEN) &&
                 (rx_byte == gcam_pkg::expected_byte(index_reg, ack_class, ack_id));

    always_comb begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        elapsed_next = elapsed_reg;
        unique case (opcode)
            gcam_pkg::OP_START: begin
                phase_next   = gcam_pkg::ST_WAIT;
                index_next   = 4'd0;
                elapsed_next = 17'd0;
            end
            gcam_pkg::OP_BYTE: begin
                if (phase_reg == gcam_pkg::ST_WAIT) begin
                    index_next = hit ? index_reg + 4'd1 : 4'd0;
                    if (index_next >= gcam_pkg::PACKET_LEN) begin
                        phase_next = gcam_pkg::ST_ACKED;
                    end
                end
            end
            gcam_pkg::OP_TICK: begin
                if (phase_reg == gcam_pkg::ST_WAIT) begin
                    if (elapsed_reg < gcam_pkg::ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + 17'd1;
                    end
                    if (elapsed_next > {1'b0, timeout_ticks}) begin
                        phase_next = gcam_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= gcam_pkg::ST_IDLE;
            index_reg   <= 4'd0;
            elapsed_reg <= 17'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign result.status      = phase_next;
    assign result.match_count = index_next;

endmodule

`default_nettype wire

// File: sv/gnss_config_ack_matcher.sv
// GNSS configuration acknowledgement matcher, top level.
// Holds configuration registers and the two-entry result buffer.
// Depends on gcam_pkg and gcam_match.
//
// Input channel (s_valid/s_ready): opcode start, received byte or 1 ms tick.
// Each input transaction yields exactly one result transaction on the
// m_ channel carrying the status (idle, waiting, acknowledged, timed out)
// and the number of packet bytes matched so far.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
// index 0 ack class, 1 ack id, 2 timeout in ticks; always ready, writes
// to other indexes are dropped. Write only while no transaction is pending.
// Results are registered. Throughput: one transaction per cycle while s_ready is
// high; the matcher state updates in the accepting cycle.
// Stall: an output register plus a skid register hold up to two results;
// s_ready drops only while the skid register is occupied.
// Reset (aresetn low, synchronous): phase idle, counters zero, registers
// at class 6, id 36, timeout 3000, buffers empty.
`default_nettype none

module gnss_config_ack_matcher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [7:0]  s_rx_byte,
    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [1:0]  m_status,
    output wire logic [3:0]  m_match_count,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [7:0]  ack_class_reg;
    logic [7:0]  ack_id_reg;
    logic [15:0] timeout_ticks_reg;

    gcam_pkg::result_t result;
    gcam_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              accept, pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign pop       = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_class_reg     <= gcam_pkg::RST_ACK_CLASS;
            ack_id_reg        <= gcam_pkg::RST_ACK_ID;
            timeout_ticks_reg <= gcam_pkg::RST_TIMEOUT_TICKS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gcam_pkg::REG_ACK_CLASS:     ack_class_reg     <= cfg_data[7:0];
                gcam_pkg::REG_ACK_ID:        ack_id_reg        <= cfg_data[7:0];
                gcam_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    gcam_match u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (accept),
        .opcode        (s_opcode),
        .rx_byte       (s_rx_byte),
        .ack_class     (ack_class_reg),
        .ack_id        (ack_id_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_match_count = out_reg.match_count;

endmodule

`default_nettype wire

// File: tb/gnss_config_ack_matcher_tb.sv
`timescale 1ns / 100ps
// Testbench for gnss_config_ack_matcher: sends start, byte and tick transactions,
// predicts status and match count per transaction and checks every result.
// Depends on gcam_pkg and the matcher RTL.

module gnss_config_ack_matcher_tb;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = gcam_pkg::OP_NONE;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_match_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = gcam_pkg::REG_ACK_CLASS;
    logic [15:0] cfg_data = 16'h0000;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    logic [7:0]  cfg_class = gcam_pkg::RST_ACK_CLASS;
    logic [7:0]  cfg_id = gcam_pkg::RST_ACK_ID;
    logic [15:0] cfg_timeout = gcam_pkg::RST_TIMEOUT_TICKS;
    logic [1:0]  ack_phase = gcam_pkg::ST_IDLE;
    logic [3:0]  ack_index = '0;
    logic [16:0] elapsed = '0;

    gcam_pkg::result_t expected_results[$];
    int items_sent = 0;
    int results_checked = 0;
    int acks_seen = 0;
    int timeouts_seen = 0;
    int fail_count = 0;

    gnss_config_ack_matcher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_match_count (m_match_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] ack_packet_byte(input logic [3:0] pos);
        logic [7:0] pkt [10];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        pkt = '{gcam_pkg::SYNC_1, gcam_pkg::SYNC_2, gcam_pkg::ACK_CLASS, gcam_pkg::ACK_ID,
                gcam_pkg::LEN_LO, gcam_pkg::LEN_HI, cfg_class, cfg_id, 8'h00, 8'h00};
        ck_a = 8'h00;
        ck_b = 8'h00;
        for (int i = 2; i < 8; i++) begin
            ck_a = ck_a + pkt[i];
            ck_b = ck_b + ck_a;
        end
        pkt[8] = ck_a;
        pkt[9] = ck_b;
        return pkt[pos];
    endfunction

    task automatic update_ack_state(input logic [1:0] op, input logic [7:0] b);
        gcam_pkg::result_t r;
        case (op)
            gcam_pkg::OP_START: begin
                ack_phase = gcam_pkg::ST_WAIT;
                ack_index = '0;
                elapsed = '0;
            end
            gcam_pkg::OP_BYTE: if (ack_phase == gcam_pkg::ST_WAIT) begin
                if (ack_index < gcam_pkg::PACKET_LEN && b == ack_packet_byte(ack_index))
                    ack_index = ack_index + 4'd1;
                else
                    ack_index = '0;
                if (ack_index >= gcam_pkg::PACKET_LEN) begin
                    ack_phase = gcam_pkg::ST_ACKED;
                    acks_seen++;
                end
            end
            gcam_pkg::OP_TICK: if (ack_phase == gcam_pkg::ST_WAIT) begin
                if (elapsed < gcam_pkg::ELAPSED_MAX)
                    elapsed = elapsed + 17'd1;
                if (elapsed > {1'b0, cfg_timeout}) begin
                    ack_phase = gcam_pkg::ST_TIMEOUT;
                    timeouts_seen++;
                end
            end
            default: ;
        endcase
        r.status = ack_phase;
        r.match_count = ack_index;
        expected_results.push_back(r);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_opcode <= 2'($urandom);
            s_rx_byte <= 8'($urandom);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        update_ack_state(op, b);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            gcam_pkg::REG_ACK_CLASS:     cfg_class = val[7:0];
            gcam_pkg::REG_ACK_ID:        cfg_id = val[7:0];
            gcam_pkg::REG_TIMEOUT_TICKS: cfg_timeout = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_packet(input int count);
        for (int pos = 0; pos < count; pos++)
            send_item(gcam_pkg::OP_BYTE, ack_packet_byte(4'(pos)));
    endtask

    always @(posedge aclk) begin : check_results
        gcam_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 40)
                    $display("%0t: result with none expected, actual status %0d count %0d",
                             $time, m_status, m_match_count);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_status);
                end
                if (m_match_count !== want.match_count) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t: match_count mismatch, expected %0d, actual %0d",
                                 $time, want.match_count, m_match_count);
                end
            end
        end
    end

    task automatic test_idle_ignores();
        send_item(gcam_pkg::OP_TICK, 8'h00);
        send_item(gcam_pkg::OP_BYTE, gcam_pkg::SYNC_1);
        send_item(gcam_pkg::OP_NONE, 8'hFF);
    endtask

    task automatic test_full_ack();
        send_item(gcam_pkg::OP_START, 8'h00);
        send_packet(10);
        send_item(gcam_pkg::OP_BYTE, 8'hFF);
        send_item(gcam_pkg::OP_TICK, 8'h00);
    endtask

    task automatic test_zero_timeout();
        write_reg(gcam_pkg::REG_TIMEOUT_TICKS, 16'h0000);
        send_item(gcam_pkg::OP_START, 8'hFF);
        send_item(gcam_pkg::OP_TICK, 8'h00);
        send_item(gcam_pkg::OP_START, 8'h00);
        send_packet(2);
        send_item(gcam_pkg::OP_TICK, 8'h00);
    endtask

    task automatic test_mismatch_restart();
        send_item(gcam_pkg::OP_START, 8'h00);
        send_item(gcam_pkg::OP_BYTE, gcam_pkg::SYNC_1);
        send_item(gcam_pkg::OP_BYTE, gcam_pkg::SYNC_1);
        send_item(gcam_pkg::OP_BYTE, gcam_pkg::SYNC_2);
        send_item(gcam_pkg::OP_NONE, 8'h5A);
    endtask

    task automatic test_max_config();
        write_reg(gcam_pkg::REG_ACK_CLASS, 16'hFFFF);
        write_reg(gcam_pkg::REG_ACK_ID, 16'hFFFF);
        write_reg(gcam_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        send_item(gcam_pkg::OP_START, 8'h00);
        send_packet(10);
        send_item(gcam_pkg::OP_START, 8'h00);
        send_packet(9);
        repeat (20) send_item(gcam_pkg::OP_TICK, 8'($urandom));
        send_item(gcam_pkg::OP_BYTE, 8'($urandom));
    endtask

    task automatic reconfigure();
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] limit;
        case ($urandom_range(3))
            0: begin
                cls = 8'h00;
                id = 8'hFF;
            end
            1: begin
                cls = 8'hFF;
                id = 8'h00;
            end
            default: begin
                cls = 8'($urandom);
                id = 8'($urandom);
            end
        endcase
        case ($urandom_range(5))
            0: limit = 16'h0000;
            1: limit = 16'hFFFF;
            default: limit = 16'($urandom_range(1, 40));
        endcase
        write_reg(gcam_pkg::REG_ACK_CLASS, {8'($urandom), cls});
        write_reg(gcam_pkg::REG_ACK_ID, {8'($urandom), id});
        write_reg(gcam_pkg::REG_TIMEOUT_TICKS, limit);
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
    endtask

    task automatic random_session();
        int kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            send_item(gcam_pkg::OP_START, 8'($urandom));
            for (int pos = 0; pos < 10; pos++) begin
                while ($urandom_range(99) < 15)
                    send_item(gcam_pkg::OP_TICK, 8'($urandom));
                if ($urandom_range(99) < 6)
                    send_item(gcam_pkg::OP_BYTE, 8'($urandom));
                if ($urandom_range(99) < 2)
                    send_item(gcam_pkg::OP_START, 8'($urandom));
                send_item(gcam_pkg::OP_BYTE, ack_packet_byte(4'(pos)));
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 8))
                send_item(2'($urandom), 8'($urandom));
        end else begin
            send_item(gcam_pkg::OP_START, 8'($urandom));
            send_packet($urandom_range(0, 9));
            repeat ($urandom_range(1, 6))
                send_item($urandom_range(1) ? gcam_pkg::OP_TICK : gcam_pkg::OP_BYTE,
                          8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int quota);
        int first;
        drain_results();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < quota) begin
            if ($urandom_range(99) < 8)
                reconfigure();
            random_session();
        end
    endtask

    task automatic test_random_traffic();
        write_reg(gcam_pkg::REG_ACK_CLASS, 16'h0000);
        write_reg(gcam_pkg::REG_ACK_ID, 16'h0000);
        write_reg(gcam_pkg::REG_TIMEOUT_TICKS, 16'd20);
        run_random_phase(0, 0, 220);
        run_random_phase(83, 0, 220);
        run_random_phase(0, 83, 220);
        run_random_phase(24, 24, 220);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_ignores();
        test_full_ack();
        test_zero_timeout();
        test_mismatch_restart();
        test_max_config();
        test_random_traffic();
        drain_results();
        repeat (5) @(posedge aclk);
        $display("Sent %0d transactions, checked %0d results, %0d mismatches",
                 items_sent, results_checked, fail_count);
        $display("Covered %0d acknowledgements and %0d timeouts over several register settings",
                 acks_seen, timeouts_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
